// File: rtl/kip_pkg.sv
`default_nettype none
package kip_pkg;
    localparam int MaxKeyframes = 8;
    localparam int Channels     = 5;
    localparam int KeyAw        = $clog2(MaxKeyframes);
    localparam int CountW       = $clog2(MaxKeyframes + 1);
    localparam int DataW        = 32;
    localparam int StepW        = 12;
    localparam int DivIters     = 33;
    localparam int IterW        = $clog2(DivIters + 1);

    typedef enum logic [1:0] {
        MODE_TICK  = 2'd0,
        MODE_SET   = 2'd1,
        MODE_SAVE  = 2'd2,
        MODE_PLAY  = 2'd3
    } mode_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD0,
        ST_RD1,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef logic signed [DataW-1:0] chan_t;

    typedef struct packed {
        logic start;
        logic load_pose;
        logic add;
    } lane_ctl_t;
endpackage
`default_nettype wire

// File: rtl/kip_ram.sv
`default_nettype none
module kip_ram #(
    parameter int Width = 32,
    parameter int Depth = 8
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] waddr,
    input  wire logic [Width-1:0]         wdata,
    input  wire logic [$clog2(Depth)-1:0] raddr,
    output logic      [Width-1:0]         rdata
);
    logic [Width-1:0] mem [Depth];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// File: rtl/kip_lane.sv
`default_nettype none
module kip_lane
    import kip_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire lane_ctl_t        ctl,
    input  wire logic             set_pose,
    input  wire chan_t            set_value,
    input  wire chan_t            key_a,
    input  wire chan_t            key_b,
    input  wire logic [StepW-1:0] steps,
    output chan_t                 pose,
    output logic                  div_done
);
    logic [DataW:0]    num_reg, num_next;
    logic [DataW:0]    rem_reg, rem_next;
    logic              neg_reg, neg_next;
    logic [IterW-1:0]  it_reg, it_next;
    logic              busy_reg, busy_next;
    chan_t             pose_reg, pose_next;
    chan_t             delta_reg, delta_next;
    logic signed [DataW:0] diff;
    logic [DataW:0]    trial;
    logic [DataW:0]    sh;
    logic signed [DataW+1:0] sq;
    logic signed [DataW+1:0] sum;

    assign diff = {key_b[DataW-1], key_b} - {key_a[DataW-1], key_a};
    assign sh    = {rem_reg[DataW-1:0], num_reg[DataW]};
    assign trial = sh - {{(DataW+1-StepW){1'b0}}, steps};
    assign sum   = {{2{pose_reg[DataW-1]}}, pose_reg} + {{2{delta_reg[DataW-1]}}, delta_reg};

    always_comb
    begin
        num_next   = num_reg;
        rem_next   = rem_reg;
        neg_next   = neg_reg;
        it_next    = it_reg;
        busy_next  = busy_reg;
        pose_next  = pose_reg;
        delta_next = delta_reg;
        sq         = '0;
        if (ctl.start)
        begin
            neg_next  = diff[DataW];
            num_next  = diff[DataW] ? -diff : diff;
            rem_next  = '0;
            it_next   = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            num_next = {num_reg[DataW-1:0], ~trial[DataW]};
            rem_next = trial[DataW] ? sh : trial;
            it_next  = it_reg + 1'b1;
            if (it_reg == IterW'(DivIters - 1))
            begin
                busy_next = 1'b0;
                sq = neg_reg ? -$signed({1'b0, num_reg[DataW-1:0], ~trial[DataW]})
                             : $signed({1'b0, num_reg[DataW-1:0], ~trial[DataW]});
                if (sq > 34'sh07fffffff)
                    delta_next = 32'sh7fffffff;
                else if (sq < -34'sh080000000)
                    delta_next = 32'sh80000000;
                else
                    delta_next = sq[DataW-1:0];
            end
        end
        if (ctl.load_pose)
            pose_next = key_a;
        else if (set_pose)
            pose_next = set_value;
        else if (ctl.add)
        begin
            if (sum > 34'sh07fffffff)
                pose_next = 32'sh7fffffff;
            else if (sum < -34'sh080000000)
                pose_next = 32'sh80000000;
            else
                pose_next = sum[DataW-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            it_reg    <= '0;
            pose_reg  <= '0;
            delta_reg <= '0;
        end
        else
        begin
            busy_reg  <= busy_next;
            it_reg    <= it_next;
            pose_reg  <= pose_next;
            delta_reg <= delta_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        neg_reg <= neg_next;
    end

    assign pose     = pose_reg;
    assign div_done = ~busy_reg;
endmodule
`default_nettype wire

// File: rtl/keyframe_interpolation_player_unit.sv
// channel   | dir | handshake                      | payload
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata: new_x..new_turn (160b), tuser: mode
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata: pose_x..pose_turn,playing,
//           |     |                                |   segment,frames_stored,refused (176b)
// cfg       | in  | cfg_valid / cfg_ready          | cfg_data: steps_per_segment
// Set, save, stop and plain ticks go from acceptance to ST_OUT, then to the output register.
// A play start or segment change first passes the keyframe RAM read states ST_RD0 and ST_RD1,
// then ST_DIV with the per-lane restoring divider (33 iterations), then ST_OUT.
// One transaction is worked at a time; a result waits in the output stage while
// the output register still holds an unread result, and input waits meanwhile.
// Reset clears control, pose and deltas; keyframe RAMs stay unwritten.
`default_nettype none
module keyframe_interpolation_player_unit
    import kip_pkg::*;
(
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         s_axis_tvalid,
    output logic              s_axis_tready,
    input  wire logic [159:0] s_axis_tdata,  // new_x, new_y, new_z, new_knee, new_turn
    input  wire logic [1:0]   s_axis_tuser,  // mode
    output logic              m_axis_tvalid,
    input  wire logic         m_axis_tready,
    output logic [175:0]      m_axis_tdata,  // pose_x..pose_turn, playing, segment,
                                             // frames_stored, request_refused, pad
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [11:0]  cfg_data
);
    state_t state_reg, state_next;
    logic [StepW-1:0]  steps_reg;
    logic [CountW-1:0] fc_reg, fc_next;
    logic              act_reg, act_next;
    logic [KeyAw-1:0]  seg_reg, seg_next;
    logic [StepW-1:0]  sc_reg, sc_next;
    logic              ref_reg, ref_next;
    logic              load_reg, load_next;
    logic              ov_reg;
    logic [175:0]      od_reg;
    logic [StepW-1:0]  steps_eff;
    logic              accept;
    logic              out_load;
    mode_t             mode;
    logic [KeyAw-1:0]  raddr;
    logic              we;
    lane_ctl_t         ctl;
    chan_t             pose [Channels];
    chan_t             ka [Channels];
    chan_t             kb [Channels];
    chan_t             rd [Channels];
    logic [Channels-1:0] done;

    assign steps_eff     = (steps_reg == '0) ? StepW'(1) : steps_reg;
    assign s_axis_tready = (state_reg == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign mode          = mode_t'(s_axis_tuser);
    assign cfg_ready     = 1'b1;
    assign we            = accept && mode == MODE_SAVE && fc_reg < CountW'(MaxKeyframes);
    assign out_load      = (state_reg == ST_OUT) && (!ov_reg || m_axis_tready);

    always_comb
    begin
        state_next = state_reg;
        fc_next    = fc_reg;
        act_next   = act_reg;
        seg_next   = seg_reg;
        sc_next    = sc_reg;
        ref_next   = ref_reg;
        load_next  = load_reg;
        ctl        = '0;
        raddr      = seg_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ref_next   = 1'b0;
                    load_next  = 1'b0;
                    state_next = ST_OUT;
                    case (mode)
                        MODE_SET: ;
                        MODE_SAVE:
                        begin
                            if (we)
                                fc_next = fc_reg + 1'b1;
                            else
                                ref_next = 1'b1;
                        end
                        MODE_PLAY:
                        begin
                            if (!act_reg && fc_reg >= CountW'(2))
                            begin
                                seg_next   = '0;
                                sc_next    = '0;
                                act_next   = 1'b1;
                                load_next  = 1'b1;
                                state_next = ST_RD0;
                            end
                            else
                            begin
                                ref_next = !act_reg;
                                act_next = 1'b0;
                                seg_next = '0;
                            end
                        end
                        default:
                        begin
                            if (act_reg)
                            begin
                                if (sc_reg >= steps_eff)
                                begin
                                    if ({1'b0, seg_reg} + 4'd3 > fc_reg)
                                    begin
                                        seg_next = '0;
                                        act_next = 1'b0;
                                    end
                                    else
                                    begin
                                        seg_next   = seg_reg + 1'b1;
                                        sc_next    = '0;
                                        state_next = ST_RD0;
                                    end
                                end
                                else
                                begin
                                    ctl.add = 1'b1;
                                    sc_next = sc_reg + 1'b1;
                                end
                            end
                        end
                    endcase
                end
                raddr = seg_next;
            end
            ST_RD0:
            begin
                raddr      = seg_reg + 1'b1;
                state_next = ST_RD1;
            end
            ST_RD1:
            begin
                ctl.start     = 1'b1;
                ctl.load_pose = load_reg;
                state_next    = ST_DIV;
            end
            ST_DIV:
            begin
                if (&done)
                    state_next = ST_OUT;
            end
            ST_OUT:
            begin
                if (out_load)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    genvar g;
    generate
        for (g = 0; g < Channels; g++)
        begin : g_lane
            kip_ram #(.Width(DataW), .Depth(MaxKeyframes)) u_ram (
                .clk   (clk),
                .we    (we),
                .waddr (fc_reg[KeyAw-1:0]),
                .wdata (pose[g]),
                .raddr (raddr),
                .rdata (rd[g])
            );
            always_ff @(posedge clk)
            begin
                if (state_reg == ST_RD0)
                    ka[g] <= rd[g];
            end
            assign kb[g] = rd[g];
            kip_lane u_lane (
                .clk       (clk),
                .rst_n     (rst_n),
                .ctl       (ctl),
                .set_pose  (accept && mode == MODE_SET),
                .set_value (s_axis_tdata[g*DataW +: DataW]),
                .key_a     (ka[g]),
                .key_b     (kb[g]),
                .steps     (steps_eff),
                .pose      (pose[g]),
                .div_done  (done[g])
            );
        end
    endgenerate

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            steps_reg <= StepW'(60);
            fc_reg    <= '0;
            act_reg   <= 1'b0;
            seg_reg   <= '0;
            sc_reg    <= '0;
            ref_reg   <= 1'b0;
            load_reg  <= 1'b0;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fc_reg    <= fc_next;
            act_reg   <= act_next;
            seg_reg   <= seg_next;
            sc_reg    <= sc_next;
            ref_reg   <= ref_next;
            load_reg  <= load_next;
            if (cfg_valid && cfg_ready)
                steps_reg <= cfg_data;
            if (out_load)
                ov_reg <= 1'b1;
            else if (m_axis_tready)
                ov_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
            od_reg <= {7'b0, ref_reg, 4'(fc_reg), seg_reg, act_reg,
                       pose[4], pose[3], pose[2], pose[1], pose[0]};
    end

    assign m_axis_tvalid = ov_reg;
    assign m_axis_tdata  = od_reg;
endmodule
`default_nettype wire

// File: rtl/kip_checker.sv
`default_nettype none
module kip_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         s_axis_tvalid,
    input wire logic         s_axis_tready,
    input wire logic         m_axis_tvalid,
    input wire logic         m_axis_tready,
    input wire logic [175:0] m_axis_tdata
);
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output not held");
    a_one: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second transaction taken");
    a_seg: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[160] |-> m_axis_tdata[163:161] == 3'd0)
        else $error("segment while idle");
    a_fc: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[167:164] <= 4'd8)
        else $error("frame count");
endmodule

bind keyframe_interpolation_player_unit kip_checker u_kip_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);
`default_nettype wire
